// ===== sv/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared shorthands for clocked concurrent assertions with synchronous reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/cpu16ex_pkg.sv =====
// ============================================================================
// cpu16ex_pkg
// Types, codes and sizes shared by the 16-bit execution unit modules.
// ============================================================================
package cpu16ex_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int WORD_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;

    // Operation codes.
    localparam logic [2:0] OP_MOV = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_CMP = 3'd3;
    localparam logic [2:0] OP_JNE = 3'd4;

    // Source operand kinds.
    localparam logic [1:0] SRC_REG = 2'd0;
    localparam logic [1:0] SRC_IMM = 2'd1;
    localparam logic [1:0] SRC_MEM = 2'd2;

    // Destination operand kinds.
    localparam logic DST_REG = 1'b0;
    localparam logic DST_MEM = 1'b1;

    localparam logic [WORD_W-1:0] BYTE_MASK = 16'h00FF;

    typedef struct packed {
        logic [2:0]        op;
        logic              dst_kind;
        logic [2:0]        dst_reg;
        logic [1:0]        src_kind;
        logic [2:0]        src_reg;
        logic              wide;
        logic [WORD_W-1:0] imm_value;
        logic [3:0]        base_reg;
        logic [3:0]        index_reg;
        logic [WORD_W-1:0] displacement;
        logic [2:0]        length;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] next_ip;
        logic              zero_flag;
        logic              sign_flag;
        logic [WORD_W-1:0] result_value;
        logic              wrote_back;
    } t_result;

    // What the execute logic hands back to the control.
    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              wrote;
        logic              reg_we;
        logic              mem_we;
        logic              flags_we;
        logic              zf;
        logic              sf;
        logic [WORD_W-1:0] reg_wdata;
    } t_alu_out;

endpackage

// ===== sv/cpu16ex_regfile.sv =====
// ============================================================================
// cpu16ex_regfile
// Eight-word register file: two registered read ports, one write port.
// A read at the same edge as a write to that entry returns the new word.
// ============================================================================
module cpu16ex_regfile (
    input  logic                                i_clk,
    input  logic                                i_re,
    input  logic [cpu16ex_pkg::REG_IDX_W-1:0]   i_raddr0,
    input  logic [cpu16ex_pkg::REG_IDX_W-1:0]   i_raddr1,
    output logic [cpu16ex_pkg::WORD_W-1:0]      o_rdata0,
    output logic [cpu16ex_pkg::WORD_W-1:0]      o_rdata1,
    input  logic                                i_we,
    input  logic [cpu16ex_pkg::REG_IDX_W-1:0]   i_waddr,
    input  logic [cpu16ex_pkg::WORD_W-1:0]      i_wdata
);

    logic [cpu16ex_pkg::WORD_W-1:0] r_mem [cpu16ex_pkg::NUM_REGS];
    logic [cpu16ex_pkg::WORD_W-1:0] r_rdata0;
    logic [cpu16ex_pkg::WORD_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= (i_we && (i_waddr == i_raddr0)) ? i_wdata : r_mem[i_raddr0];
            r_rdata1 <= (i_we && (i_waddr == i_raddr1)) ? i_wdata : r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== sv/cpu16ex_dmem.sv =====
// ============================================================================
// cpu16ex_dmem
// Byte data memory split into an even and an odd bank so that a word at any
// address is one row access in each bank. Read data is registered.
// ============================================================================
module cpu16ex_dmem #(
    parameter int ADDR_BITS = cpu16ex_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_re,
    input  logic [ADDR_BITS-2:0]              i_rrow_even,
    input  logic [ADDR_BITS-2:0]              i_rrow_odd,
    output logic [cpu16ex_pkg::BYTE_W-1:0]    o_rdata_even,
    output logic [cpu16ex_pkg::BYTE_W-1:0]    o_rdata_odd,
    input  logic                              i_we_even,
    input  logic                              i_we_odd,
    input  logic [ADDR_BITS-2:0]              i_wrow_even,
    input  logic [ADDR_BITS-2:0]              i_wrow_odd,
    input  logic [cpu16ex_pkg::BYTE_W-1:0]    i_wdata_even,
    input  logic [cpu16ex_pkg::BYTE_W-1:0]    i_wdata_odd
);

    localparam int ROWS = 2 ** (ADDR_BITS - 1);

    logic [cpu16ex_pkg::BYTE_W-1:0] r_even [ROWS];
    logic [cpu16ex_pkg::BYTE_W-1:0] r_odd  [ROWS];
    logic [cpu16ex_pkg::BYTE_W-1:0] r_rdata_even;
    logic [cpu16ex_pkg::BYTE_W-1:0] r_rdata_odd;

    always_ff @(posedge i_clk) begin
        if (i_we_even) begin
            r_even[i_wrow_even] <= i_wdata_even;
        end
        if (i_re) begin
            r_rdata_even <= r_even[i_rrow_even];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we_odd) begin
            r_odd[i_wrow_odd] <= i_wdata_odd;
        end
        if (i_re) begin
            r_rdata_odd <= r_odd[i_rrow_odd];
        end
    end

    assign o_rdata_even = r_rdata_even;
    assign o_rdata_odd  = r_rdata_odd;

endmodule

// ===== sv/cpu16ex_alu.sv =====
// ============================================================================
// cpu16ex_alu
// Operand selection, add and subtract, flags and byte merge for write-back.
// ============================================================================
module cpu16ex_alu (
    input  cpu16ex_pkg::t_item                i_item,
    input  logic [cpu16ex_pkg::WORD_W-1:0]    i_src_word,
    input  logic [cpu16ex_pkg::WORD_W-1:0]    i_dst_word,
    input  logic [cpu16ex_pkg::WORD_W-1:0]    i_mem_word,
    output cpu16ex_pkg::t_alu_out             o_alu
);

    logic [cpu16ex_pkg::WORD_W-1:0] wmask;
    logic [cpu16ex_pkg::WORD_W-1:0] src_val;
    logic [cpu16ex_pkg::WORD_W-1:0] dst_val;
    logic [cpu16ex_pkg::WORD_W-1:0] sum;
    logic [cpu16ex_pkg::WORD_W-1:0] diff;
    logic [cpu16ex_pkg::WORD_W-1:0] result;
    logic                           wrote;
    logic                           flags_we;

    // Register operand: the whole word, or the low or high byte of it.
    function automatic logic [cpu16ex_pkg::WORD_W-1:0] reg_pick(
        input logic [cpu16ex_pkg::WORD_W-1:0] word,
        input logic [2:0]                     code,
        input logic                           wide
    );
        logic [cpu16ex_pkg::WORD_W-1:0] v;
        if (wide) begin
            v = word;
        end else if (code[2]) begin
            v = {8'h00, word[15:8]};
        end else begin
            v = {8'h00, word[7:0]};
        end
        return v;
    endfunction

    assign wmask = i_item.wide ? 16'hFFFF : cpu16ex_pkg::BYTE_MASK;

    always_comb begin
        case (i_item.src_kind)
            cpu16ex_pkg::SRC_REG: src_val = reg_pick(i_src_word, i_item.src_reg, i_item.wide);
            cpu16ex_pkg::SRC_IMM: src_val = i_item.imm_value & wmask;
            cpu16ex_pkg::SRC_MEM: src_val = i_mem_word;
            default:              src_val = '0;
        endcase
    end

    assign dst_val = (i_item.dst_kind == cpu16ex_pkg::DST_MEM) ? i_mem_word
                   : reg_pick(i_dst_word, i_item.dst_reg, i_item.wide);
    assign sum  = dst_val + src_val;
    assign diff = dst_val - src_val;

    always_comb begin
        result   = '0;
        wrote    = 1'b0;
        flags_we = 1'b0;
        case (i_item.op)
            cpu16ex_pkg::OP_MOV: begin
                result = src_val & wmask;
                wrote  = 1'b1;
            end
            cpu16ex_pkg::OP_ADD: begin
                result   = sum & wmask;
                wrote    = 1'b1;
                flags_we = 1'b1;
            end
            cpu16ex_pkg::OP_SUB: begin
                result   = diff & wmask;
                wrote    = 1'b1;
                flags_we = 1'b1;
            end
            cpu16ex_pkg::OP_CMP: begin
                result   = diff & wmask;
                flags_we = 1'b1;
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_comb begin
        o_alu.result   = result;
        o_alu.wrote    = wrote;
        o_alu.reg_we   = wrote && (i_item.dst_kind == cpu16ex_pkg::DST_REG);
        o_alu.mem_we   = wrote && (i_item.dst_kind == cpu16ex_pkg::DST_MEM);
        o_alu.flags_we = flags_we;
        o_alu.zf       = (result == '0);
        o_alu.sf       = i_item.wide ? result[15] : result[7];
        // A byte write keeps the other half of the destination word.
        if (i_item.wide) begin
            o_alu.reg_wdata = result;
        end else if (i_item.dst_reg[2]) begin
            o_alu.reg_wdata = {result[7:0], i_dst_word[7:0]};
        end else begin
            o_alu.reg_wdata = {i_dst_word[15:8], result[7:0]};
        end
    end

endmodule

// ===== sv/cpu16_execute_mov_add_sub_cmp_jne.sv =====
// ============================================================================
// cpu16_execute_mov_add_sub_cmp_jne
// Execution unit for decoded MOV, ADD, SUB, CMP and JNE instructions.
// ============================================================================
// Each accepted beat is one decoded instruction and yields one result beat.
// An instruction passes an address phase that forms its memory address (address
// terms read from the register file) and an execute phase (source, destination
// and memory operands read, result written back), so the unit does not start
// the next instruction before the last one finishes executing; the two read
// ports of the register file and the read then write-back of the data memory
// keep the phases apart. A one-entry input buffer takes the next beat while an
// instruction executes, and an output register holds a result until it is
// taken. After reset the data memory and registers are cleared by a sweep over
// all 2**(ADDR_BITS-1) rows of each bank (32768 at the default), during which no
// instruction is accepted.
`include "assert_macros.svh"

module cpu16_execute_mov_add_sub_cmp_jne #(
    parameter int ADDR_BITS = cpu16ex_pkg::ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cpu16ex_pkg::t_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cpu16ex_pkg::t_result  o_out_result
);

    localparam int ROW_W = ADDR_BITS - 1;

    typedef enum logic [3:0] {
        PH_CLEAR = 4'b0001,
        PH_IDLE  = 4'b0010,
        PH_ADDR  = 4'b0100,
        PH_EXEC  = 4'b1000
    } t_phase;

    t_phase                          r_phase;
    t_phase                          n_phase;
    logic [ROW_W-1:0]                r_clr_cnt;
    logic                            r_hold_v;
    cpu16ex_pkg::t_item              r_hold;
    cpu16ex_pkg::t_item              r_item;
    logic [ROW_W-1:0]                r_even_row;
    logic [ROW_W-1:0]                r_odd_row;
    logic                            r_odd;
    logic [cpu16ex_pkg::WORD_W-1:0]  r_ip;
    logic                            r_zf;
    logic                            r_sf;
    logic                            r_out_v;
    cpu16ex_pkg::t_result            r_out;

    logic                            clearing;
    logic                            exec_done;
    logic                            start;
    logic                            in_acc;

    logic                            rf_re;
    logic [cpu16ex_pkg::REG_IDX_W-1:0] rf_raddr0;
    logic [cpu16ex_pkg::REG_IDX_W-1:0] rf_raddr1;
    logic [cpu16ex_pkg::WORD_W-1:0]  rf_rd0;
    logic [cpu16ex_pkg::WORD_W-1:0]  rf_rd1;
    logic                            rf_we;
    logic [cpu16ex_pkg::REG_IDX_W-1:0] rf_waddr;
    logic [cpu16ex_pkg::WORD_W-1:0]  rf_wdata;

    logic [cpu16ex_pkg::WORD_W-1:0]  base_term;
    logic [cpu16ex_pkg::WORD_W-1:0]  index_term;
    logic [cpu16ex_pkg::WORD_W-1:0]  ea;
    logic [cpu16ex_pkg::WORD_W-1:0]  ea_next;
    logic [ADDR_BITS-1:0]            lo_addr;
    logic [ADDR_BITS-1:0]            hi_addr;
    logic [ROW_W-1:0]                even_row_a;
    logic [ROW_W-1:0]                odd_row_a;

    logic                            dm_re;
    logic [cpu16ex_pkg::BYTE_W-1:0]  dm_even_q;
    logic [cpu16ex_pkg::BYTE_W-1:0]  dm_odd_q;
    logic                            mem_wr;
    logic                            dm_we_even;
    logic                            dm_we_odd;
    logic [ROW_W-1:0]                dm_wrow_even;
    logic [ROW_W-1:0]                dm_wrow_odd;
    logic [cpu16ex_pkg::BYTE_W-1:0]  dm_wdata_even;
    logic [cpu16ex_pkg::BYTE_W-1:0]  dm_wdata_odd;

    logic [cpu16ex_pkg::BYTE_W-1:0]  mem_lo;
    logic [cpu16ex_pkg::BYTE_W-1:0]  mem_hi;
    logic [cpu16ex_pkg::WORD_W-1:0]  mem_word;
    cpu16ex_pkg::t_alu_out           alu;

    logic [cpu16ex_pkg::WORD_W-1:0]  ip_step;
    logic [cpu16ex_pkg::WORD_W-1:0]  jmp_disp;
    logic                            jmp_taken;
    logic [cpu16ex_pkg::WORD_W-1:0]  ip_next;
    logic                            zf_next;
    logic                            sf_next;

    // Word register that holds a byte or word register code.
    function automatic logic [cpu16ex_pkg::REG_IDX_W-1:0] word_idx(
        input logic [2:0] code,
        input logic       wide
    );
        return wide ? code : {1'b0, code[1:0]};
    endfunction

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign clearing   = (r_phase == PH_CLEAR);
    assign exec_done  = (r_phase == PH_EXEC) && (!r_out_v || i_out_ready);
    assign start      = r_hold_v && ((r_phase == PH_IDLE) || exec_done);
    assign o_in_ready = !clearing && (!r_hold_v || start);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_CLEAR: begin
                if (&r_clr_cnt) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_IDLE: begin
                if (start) begin
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                n_phase = PH_EXEC;
            end
            PH_EXEC: begin
                if (exec_done) begin
                    n_phase = start ? PH_ADDR : PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CLEAR;
            r_clr_cnt <= '0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_ip      <= '0;
            r_zf      <= 1'b0;
            r_sf      <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (in_acc) begin
                r_hold_v <= 1'b1;
            end else if (start) begin
                r_hold_v <= 1'b0;
            end
            if (exec_done) begin
                r_out_v <= 1'b1;
                r_ip    <= ip_next;
                r_zf    <= zf_next;
                r_sf    <= sf_next;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hold <= i_in_item;
        end
        if (start) begin
            r_item <= r_hold;
        end
        if (r_phase == PH_ADDR) begin
            r_even_row <= even_row_a;
            r_odd_row  <= odd_row_a;
            r_odd      <= lo_addr[0];
        end
        if (exec_done) begin
            r_out.next_ip      <= ip_next;
            r_out.zero_flag    <= zf_next;
            r_out.sign_flag    <= sf_next;
            r_out.result_value <= alu.result;
            r_out.wrote_back   <= alu.wrote;
        end
    end

    // ------------------------------------------------------------------
    // Register file: address terms at start, operands when leaving ADDR.
    // ------------------------------------------------------------------
    assign rf_re     = start || (r_phase == PH_ADDR);
    assign rf_raddr0 = start ? r_hold.base_reg[cpu16ex_pkg::REG_IDX_W-1:0]
                     : word_idx(r_item.src_reg, r_item.wide);
    assign rf_raddr1 = start ? r_hold.index_reg[cpu16ex_pkg::REG_IDX_W-1:0]
                     : word_idx(r_item.dst_reg, r_item.wide);
    assign rf_we     = clearing || (exec_done && alu.reg_we);
    assign rf_waddr  = clearing ? r_clr_cnt[cpu16ex_pkg::REG_IDX_W-1:0]
                     : word_idx(r_item.dst_reg, r_item.wide);
    assign rf_wdata  = clearing ? '0 : alu.reg_wdata;

    cpu16ex_regfile u_regfile (
        .i_clk    (i_clk),
        .i_re     (rf_re),
        .i_raddr0 (rf_raddr0),
        .i_raddr1 (rf_raddr1),
        .o_rdata0 (rf_rd0),
        .o_rdata1 (rf_rd1),
        .i_we     (rf_we),
        .i_waddr  (rf_waddr),
        .i_wdata  (rf_wdata)
    );

    // ------------------------------------------------------------------
    // Address phase. A term code of 8 or above means no register.
    // ------------------------------------------------------------------
    assign base_term  = r_item.base_reg[3]  ? '0 : rf_rd0;
    assign index_term = r_item.index_reg[3] ? '0 : rf_rd1;
    assign ea         = r_item.displacement + base_term + index_term;
    assign ea_next    = ea + 16'd1;
    assign lo_addr    = ADDR_BITS'(ea);
    assign hi_addr    = ADDR_BITS'(ea_next);

    // The byte after an odd address lives in the even bank one row up.
    assign even_row_a = lo_addr[0] ? hi_addr[ADDR_BITS-1:1] : lo_addr[ADDR_BITS-1:1];
    assign odd_row_a  = lo_addr[0] ? lo_addr[ADDR_BITS-1:1] : hi_addr[ADDR_BITS-1:1];

    // ------------------------------------------------------------------
    // Data memory
    // ------------------------------------------------------------------
    assign dm_re         = (r_phase == PH_ADDR);
    assign mem_wr        = exec_done && alu.mem_we;
    assign dm_we_even    = clearing || (mem_wr && (!r_odd || r_item.wide));
    assign dm_we_odd     = clearing || (mem_wr && (r_odd || r_item.wide));
    assign dm_wrow_even  = clearing ? r_clr_cnt : r_even_row;
    assign dm_wrow_odd   = clearing ? r_clr_cnt : r_odd_row;
    assign dm_wdata_even = clearing ? '0 : (r_odd ? alu.result[15:8] : alu.result[7:0]);
    assign dm_wdata_odd  = clearing ? '0 : (r_odd ? alu.result[7:0] : alu.result[15:8]);

    cpu16ex_dmem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dmem (
        .i_clk        (i_clk),
        .i_re         (dm_re),
        .i_rrow_even  (even_row_a),
        .i_rrow_odd   (odd_row_a),
        .o_rdata_even (dm_even_q),
        .o_rdata_odd  (dm_odd_q),
        .i_we_even    (dm_we_even),
        .i_we_odd     (dm_we_odd),
        .i_wrow_even  (dm_wrow_even),
        .i_wrow_odd   (dm_wrow_odd),
        .i_wdata_even (dm_wdata_even),
        .i_wdata_odd  (dm_wdata_odd)
    );

    assign mem_lo   = r_odd ? dm_odd_q : dm_even_q;
    assign mem_hi   = r_odd ? dm_even_q : dm_odd_q;
    assign mem_word = r_item.wide ? {mem_hi, mem_lo} : {8'h00, mem_lo};

    // ------------------------------------------------------------------
    // Execute phase
    // ------------------------------------------------------------------
    cpu16ex_alu u_alu (
        .i_item     (r_item),
        .i_src_word (rf_rd0),
        .i_dst_word (rf_rd1),
        .i_mem_word (mem_word),
        .o_alu      (alu)
    );

    assign ip_step   = r_ip + {13'd0, r_item.length};
    assign jmp_disp  = {{8{r_item.imm_value[7]}}, r_item.imm_value[7:0]};
    assign jmp_taken = (r_item.op == cpu16ex_pkg::OP_JNE) && !r_zf;
    assign ip_next   = jmp_taken ? (ip_step + jmp_disp) : ip_step;
    assign zf_next   = alu.flags_we ? alu.zf : r_zf;
    assign sf_next   = alu.flags_we ? alu.sf : r_sf;

    assign o_out_valid  = r_out_v;
    assign o_out_result = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_addr_then_exec, i_clk, i_rst_n,
        (r_phase == PH_ADDR) |=> (r_phase == PH_EXEC), "address phase not followed by execute")
    `ASSERT_CLK(a_done_shows_result, i_clk, i_rst_n,
        exec_done |=> o_out_valid, "finished instruction left no result")
    `ASSERT_CLK(a_ip_only_on_done, i_clk, i_rst_n,
        !exec_done |=> $stable(r_ip), "instruction pointer moved without an instruction")
    `ASSERT_NEVER(a_dmem_rw_apart, i_clk, i_rst_n,
        dm_re && (dm_we_even || dm_we_odd), "data memory read and written in one cycle")

endmodule
